// ===== src/vtv_pkg.sv =====
package vtv_pkg;

    localparam int VIEW_WIDTH  = 640;
    localparam int VIEW_HEIGHT = 480;
    localparam int NUM_PAIRS   = 8;
    localparam int CFG_IDX_W   = 4;
    localparam int FRAC_BITS   = 16;
    localparam int DVD_W       = 48;            // |c| << 16
    localparam int QUO_W       = DVD_W + 1;     // signed quotient
    localparam int LATENCY     = DVD_W + 4;     // lane 2, divider 1 + 48, merge 1

    localparam logic [63:0] PAIR_RESET [NUM_PAIRS] = '{
        64'd65536, 64'd0, 64'd281474976710656, 64'd0,
        64'd0, 64'd65536, 64'd0, 64'd281474976710656
    };

    typedef struct packed {
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_y;
        logic signed [31:0] vertex_z;
        logic signed [31:0] vertex_w;
    } vertex_t;

    typedef struct packed {
        logic signed [31:0] screen_x;
        logic signed [31:0] screen_y;
        logic signed [31:0] depth;
        logic               divide_fault;
    } result_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ===== src/vtv_lane.sv =====
// One clip coordinate: four products, truncate to Q16.16, sum, saturate.
module vtv_lane (
    input  logic                    clk,
    input  vtv_pkg::vertex_t        vertex,
    input  logic signed [31:0]      m0,
    input  logic signed [31:0]      m1,
    input  logic signed [31:0]      m2,
    input  logic signed [31:0]      m3,
    output logic signed [31:0]      clip
);
    import vtv_pkg::*;

    logic signed [63:0] prod_reg [4];
    logic signed [31:0] clip_reg;
    logic signed [47:0] cut [4];
    logic signed [49:0] sum;

    always_ff @(posedge clk)
    begin
        prod_reg[0] <= 64'(vertex.vertex_x) * 64'(m0);
        prod_reg[1] <= 64'(vertex.vertex_y) * 64'(m1);
        prod_reg[2] <= 64'(vertex.vertex_z) * 64'(m2);
        prod_reg[3] <= 64'(vertex.vertex_w) * 64'(m3);
    end

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < 4; i++)
        begin
            // toward zero: bias negatives before the shift
            cut[i] = 48'((prod_reg[i] + (prod_reg[i][63] ? 64'sd65535 : 64'sd0)) >>> FRAC_BITS);
            sum    = sum + 50'(cut[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        clip_reg <= sat32(64'(sum));
    end

    assign clip = clip_reg;

endmodule

// ===== src/vtv_div.sv =====
// Pipelined restoring divider, one quotient bit per stage: (num << 16) / den.
module vtv_div (
    input  logic                            clk,
    input  logic signed [31:0]              num,
    input  logic signed [31:0]              den,
    output logic signed [vtv_pkg::QUO_W-1:0] quo
);
    import vtv_pkg::*;

    logic [31:0]      rem_reg [DVD_W+1];
    logic [DVD_W-1:0] dvd_reg [DVD_W+1];
    logic [DVD_W-1:0] quo_reg [DVD_W+1];
    logic [31:0]      den_reg [DVD_W+1];
    logic             neg_reg [DVD_W+1];

    logic [31:0] num_mag;
    logic [31:0] den_mag;

    assign num_mag = num[31] ? 32'(-num) : 32'(num);
    assign den_mag = den[31] ? 32'(-den) : 32'(den);

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= '0;
        dvd_reg[0] <= {num_mag, 16'd0};
        quo_reg[0] <= '0;
        den_reg[0] <= den_mag;
        neg_reg[0] <= num[31] ^ den[31];
    end

    for (genvar k = 0; k < DVD_W; k++)
    begin : g_stage
        logic [32:0] trial;
        logic        fits;

        assign trial = {rem_reg[k], dvd_reg[k][DVD_W-1]};
        assign fits  = trial >= {1'b0, den_reg[k]};

        always_ff @(posedge clk)
        begin
            rem_reg[k+1] <= fits ? 32'(trial - {1'b0, den_reg[k]}) : trial[31:0];
            dvd_reg[k+1] <= {dvd_reg[k][DVD_W-2:0], 1'b0};
            quo_reg[k+1] <= {quo_reg[k][DVD_W-2:0], fits};
            den_reg[k+1] <= den_reg[k];
            neg_reg[k+1] <= neg_reg[k];
        end
    end

    assign quo = neg_reg[DVD_W] ? -$signed({1'b0, quo_reg[DVD_W]})
                                : $signed({1'b0, quo_reg[DVD_W]});

endmodule

// ===== src/vtv_merge.sv =====
// Viewport mapping of the three lane quotients, fault forcing, output register.
module vtv_merge (
    input  logic                             clk,
    input  logic signed [vtv_pkg::QUO_W-1:0] nx,
    input  logic signed [vtv_pkg::QUO_W-1:0] ny,
    input  logic signed [vtv_pkg::QUO_W-1:0] nz,
    input  logic                             fault,
    output vtv_pkg::result_t                 result
);
    import vtv_pkg::*;

    result_t            result_reg;
    logic signed [63:0] tx;
    logic signed [63:0] ty;
    logic signed [63:0] hx;
    logic signed [63:0] hy;

    always_comb
    begin
        tx = (64'(nx) + 64'sd65536) * 64'(VIEW_WIDTH);
        ty = (64'sd65536 - 64'(ny)) * 64'(VIEW_HEIGHT);
        hx = (tx + (tx[63] ? 64'sd1 : 64'sd0)) >>> 1;
        hy = (ty + (ty[63] ? 64'sd1 : 64'sd0)) >>> 1;
    end

    always_ff @(posedge clk)
    begin
        if (fault)
        begin
            result_reg <= '{screen_x: '0, screen_y: '0, depth: '0, divide_fault: 1'b1};
        end
        else
        begin
            result_reg.screen_x     <= sat32(hx);
            result_reg.screen_y     <= sat32(hy);
            result_reg.depth        <= sat32(64'(nz));
            result_reg.divide_fault <= 1'b0;
        end
    end

    assign result = result_reg;

endmodule

// ===== src/vertex_transform_viewport.sv =====
// Vertex transform, perspective divide and viewport mapping.
// Command channel: an item (x, y, z, w, signed Q16.16) is taken at any rising
// edge with start high; busy is always low, so one vertex may enter every cycle.
// Result channel: done pulses for one cycle with result valid alongside;
// there is no back-pressure, the receiver must take every result.
// Path from the accepting edge to the edge that takes the result:
// two lane stages (products, then sum and saturate), one divider operand stage,
// 48 quotient-bit stages, one merge stage.
// Throughput: one vertex per cycle, fixed; every stage is a pipeline register.
// Pipeline: four column lanes (4 multipliers each, then sum and saturate),
// three divider lanes sharing clip w, then a merge stage doing the viewport
// scaling and the zero-w fault (fault gives zero coordinates).
// Configuration: cfg_we writes pair_reg[cfg_index]; indexes past the
// last pair are dropped. Write only while no item is in flight.
// Reset: asynchronous, active low; restores the identity matrix and empties
// the pipeline (no done strobes until new items arrive).
module vertex_transform_viewport (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  vtv_pkg::vertex_t                 vertex,
    output logic                             done,
    output vtv_pkg::result_t                 result,
    input  logic                             cfg_we,
    input  logic [vtv_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [63:0]                      cfg_data
);
    import vtv_pkg::*;

    logic [63:0]          pair_reg  [NUM_PAIRS];
    logic [LATENCY-1:0]   valid_reg;
    logic                 fault_reg [DVD_W+1];
    logic signed [31:0]   clip [4];
    logic signed [31:0]   m [4][4];
    logic signed [QUO_W-1:0] nq [3];
    logic                 accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // matrix registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_PAIRS; k++)
                pair_reg[k] <= PAIR_RESET[k];
        end
        else if (cfg_we && cfg_index < CFG_IDX_W'(NUM_PAIRS))
        begin
            pair_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    // M[i][j] from pair i*2 + j/2, low half for even j
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            m[i][0] = pair_reg[2*i][31:0];
            m[i][1] = pair_reg[2*i][63:32];
            m[i][2] = pair_reg[2*i+1][31:0];
            m[i][3] = pair_reg[2*i+1][63:32];
        end
    end

    // item valid line, one bit per pipeline register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[LATENCY-2:0], accept};
    end

    for (genvar j = 0; j < 4; j++)
    begin : g_col
        vtv_lane u_lane (
            .clk    (clk),
            .vertex (vertex),
            .m0     (m[0][j]),
            .m1     (m[1][j]),
            .m2     (m[2][j]),
            .m3     (m[3][j]),
            .clip   (clip[j])
        );
    end

    for (genvar j = 0; j < 3; j++)
    begin : g_div
        vtv_div u_div (
            .clk (clk),
            .num (clip[j]),
            .den (clip[3]),
            .quo (nq[j])
        );
    end

    // zero-w flag rides alongside the divider stages
    always_ff @(posedge clk)
    begin
        fault_reg[0] <= (clip[3] == 32'sd0);
        for (int k = 0; k < DVD_W; k++)
            fault_reg[k+1] <= fault_reg[k];
    end

    vtv_merge u_merge (
        .clk    (clk),
        .nx     (nq[0]),
        .ny     (nq[1]),
        .nz     (nq[2]),
        .fault  (fault_reg[DVD_W]),
        .result (result)
    );

    assign done = valid_reg[LATENCY-1];

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $past(accept, LATENCY) && $past(rst_n, LATENCY) |-> done)
        else $error("accepted item did not complete on time");

    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.divide_fault |->
            result.screen_x == 32'sd0 && result.screen_y == 32'sd0 && result.depth == 32'sd0)
        else $error("fault result carries non-zero coordinates");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done) |-> $past(valid_reg[LATENCY-2]))
        else $error("done without an item in flight");
`endif

endmodule

// ===== bench/tb.sv =====
module tb;
    import vtv_pkg::*;

    // Clock, reset and DUT ports
    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    vertex_t     vertex;
    logic        done;
    result_t     result;
    logic        cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [63:0] cfg_data;

    // Predictor's own copy of the matrix registers
    logic [63:0] pair_shadow [NUM_PAIRS];

    // Projected results still owed by the DUT, oldest first
    result_t     pending_screen [$];

    int          error_count;
    int          quiet_cycles;
    int          send_idle_pct;

    localparam int QUIET_LIMIT = 20 * LATENCY + 200;

    vertex_transform_viewport DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .vertex    (vertex),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint clamp32(input longint v);
        longint r;
        if (v > 64'sd2147483647)
            r = 64'sd2147483647;
        else if (v < -64'sd2147483648)
            r = -64'sd2147483648;
        else
            r = v;
        return r;
    endfunction

    // M[i][j] from the shadow pairs, sign extended
    function automatic longint mat_entry(input int i, input int j);
        logic [63:0] p;
        logic signed [31:0] e;
        p = pair_shadow[i * 2 + j / 2];
        e = (j % 2) ? p[63:32] : p[31:0];
        return longint'(e);
    endfunction

    // Transform, divide and viewport map one vertex.
    // SV integer division truncates towards zero, as needed.
    function automatic result_t project_vertex(input vertex_t v);
        longint vin [4];
        longint clip [4];
        longint acc;
        longint nx, ny, nz;
        result_t r;
        vin[0] = longint'(v.vertex_x);
        vin[1] = longint'(v.vertex_y);
        vin[2] = longint'(v.vertex_z);
        vin[3] = longint'(v.vertex_w);
        for (int j = 0; j < 4; j++)
        begin
            acc = 0;
            for (int i = 0; i < 4; i++)
                acc += (vin[i] * mat_entry(i, j)) / 65536;
            clip[j] = clamp32(acc);
        end
        r = '0;
        if (clip[3] == 0)
            r.divide_fault = 1'b1;
        else
        begin
            nx = (clip[0] * 65536) / clip[3];
            ny = (clip[1] * 65536) / clip[3];
            nz = (clip[2] * 65536) / clip[3];
            r.screen_x = 32'(clamp32(((nx + 65536) * VIEW_WIDTH) / 2));
            r.screen_y = 32'(clamp32(((65536 - ny) * VIEW_HEIGHT) / 2));
            r.depth    = 32'(clamp32(nz));
        end
        return r;
    endfunction

    // Result checker: each done compared with the oldest prediction
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (pending_screen.size() == 0)
            begin
                $error("unexpected result %h", result);
                error_count++;
            end
            else
            begin
                want = pending_screen.pop_front();
                if (result.screen_x !== want.screen_x)
                begin
                    $error("screen_x exp %h got %h", want.screen_x, result.screen_x);
                    error_count++;
                end
                if (result.screen_y !== want.screen_y)
                begin
                    $error("screen_y exp %h got %h", want.screen_y, result.screen_y);
                    error_count++;
                end
                if (result.depth !== want.depth)
                begin
                    $error("depth exp %h got %h", want.depth, result.depth);
                    error_count++;
                end
                if (result.divide_fault !== want.divide_fault)
                begin
                    $error("divide_fault exp %b got %b", want.divide_fault,
                           result.divide_fault);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: cycles with neither an accepted item nor a result
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // Send one item, after a random gap with start low; start stays high across items sent with no gap
    task automatic send_vertex(input vertex_t v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start  <= 1'b1;
        vertex <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_screen.push_back(project_vertex(v));
    endtask

    // Let the pipeline empty before touching the matrix
    task automatic drain_pipe();
        @(negedge clk);
        start <= 1'b0;
        while (pending_screen.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_pair(input int idx, input logic [63:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IDX_W'(idx);
        cfg_data  <= data;
        if (idx < NUM_PAIRS)
            pair_shadow[idx] = data;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_word();
        logic [31:0] w;
        case ($urandom_range(5))
            0: w = 32'h7fffffff;
            1: w = 32'h80000000;
            2: w = 32'(65536 * ($urandom_range(8) - 4));
            3: w = $urandom_range(131071) - 65536;
            default: w = $urandom;
        endcase
        return w;
    endfunction

    function automatic vertex_t rand_vertex();
        vertex_t v;
        v.vertex_x = rand_word();
        v.vertex_y = rand_word();
        v.vertex_z = rand_word();
        // mostly a sensible w, sometimes anything
        v.vertex_w = ($urandom_range(3) == 0) ? rand_word() : 32'sd65536;
        return v;
    endfunction

    // Corners of the input fields and the zero-w fault under identity, then out-of-range config writes
    task automatic test_directed();
        vertex_t v;
        send_vertex('{32'sd0, 32'sd0, 32'sd0, 32'sd65536});
        send_vertex('{32'sd65536, -32'sd65536, 32'sd32768, 32'sd65536});
        send_vertex('{32'sd0, 32'sd0, 32'sd0, 32'sd0});
        send_vertex('{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff});
        send_vertex('{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000});
        send_vertex('{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sd1});
        send_vertex('{32'sh80000000, 32'sh7fffffff, 32'sh80000000, -32'sd1});
        send_vertex('{32'sd1, -32'sd1, 32'sd1, 32'sd1});
        send_vertex('{-32'sd65536, 32'sd65536, -32'sd65536, -32'sd65536});
        send_vertex('{32'sd12345, 32'sd54321, -32'sd999, 32'sd2});
        v = '1;
        send_vertex(v);
        drain_pipe();
        // out-of-range index must be dropped
        write_pair(NUM_PAIRS, 64'hdeadbeefdeadbeef);
        write_pair(15, 64'h0123456789abcdef);
        send_vertex('{32'sd65536, 32'sd65536, 32'sd65536, 32'sd65536});
        drain_pipe();
    endtask

    // Random matrices, extremes among them, random vertices
    task automatic test_random(input int n_items, input int idle_pct);
        send_idle_pct = idle_pct;
        for (int k = 0; k < n_items; k++)
        begin
            if (k % 40 == 0)
            begin
                drain_pipe();
                for (int p = 0; p < NUM_PAIRS; p++)
                    case ($urandom_range(3))
                        0: write_pair(p, PAIR_RESET[p]);
                        1: write_pair(p, {rand_word(), rand_word()});
                        2: write_pair(p, {$urandom_range(1) ? 64'h7fffffff7fffffff
                                                             : 64'h8000000080000000});
                        default: write_pair(p, {$urandom, $urandom});
                    endcase
            end
            send_vertex(rand_vertex());
        end
        drain_pipe();
    endtask

    initial
    begin
        start     = 1'b0;
        vertex    = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        rst_n     = 1'b0;
        error_count   = 0;
        quiet_cycles  = 0;
        send_idle_pct = 0;
        for (int p = 0; p < NUM_PAIRS; p++)
            pair_shadow[p] = PAIR_RESET[p];
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(140, 16);   // sender idles 16 in 100
        test_random(130, 50);   // sender idles 50 in 100
        test_random(130, 0);    // back to back

        if (error_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// ===== files.f =====
src/vtv_pkg.sv
src/vtv_lane.sv
src/vtv_div.sv
src/vtv_merge.sv
src/vertex_transform_viewport.sv
bench/tb.sv
